/* rtl/iect_pkg.sv */
// Shared types, constants and codes for the echo collision transmitter.
package iect_pkg;

   // Sizes
   localparam int FRAME_DEPTH = 256;
   localparam int TIME_WIDTH  = 32;
   localparam int ADDR_WIDTH  = $clog2(FRAME_DEPTH);
   localparam int COUNT_WIDTH = $clog2(FRAME_DEPTH) + 1;
   localparam int BYTE_WIDTH  = 8;
   localparam int CODE_WIDTH  = 3;
   localparam int CSR_INDEX_WIDTH = 2;

   // Low nibble that takes part in the pseudo-random backoff
   localparam logic [BYTE_WIDTH-1:0] BACKOFF_MASK = 8'h0f;

   // Request codes
   typedef enum logic [CODE_WIDTH-1:0] {
      REQ_TICK   = 3'd0,
      REQ_LOAD   = 3'd1,
      REQ_START  = 3'd2,
      REQ_SLOT   = 3'd3,
      REQ_RX     = 3'd4,
      REQ_RX_ERR = 3'd5
   } req_code_type;

   // Link mode; collided behaves as idle
   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_ACTIVE = 2'd1,
      MODE_COLL   = 2'd2
   } link_mode_type;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTE_SAFE_GAP = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAIT_OK       = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAIT_COLL     = 2'd2;

   localparam logic [BYTE_WIDTH-1:0] BYTE_SAFE_GAP_RESET = 8'd3;
   localparam logic [BYTE_WIDTH-1:0] WAIT_OK_RESET       = 8'd2;
   localparam logic [BYTE_WIDTH-1:0] WAIT_COLL_RESET     = 8'd8;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] code;
      logic [BYTE_WIDTH-1:0] data;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] byte_safe_gap;
      logic [BYTE_WIDTH-1:0] wait_ok;
      logic [BYTE_WIDTH-1:0] wait_coll;
   } cfg_type;

   typedef struct packed {
      logic                  send_valid;
      logic [BYTE_WIDTH-1:0] send_byte;
      logic                  forward_valid;
      logic [BYTE_WIDTH-1:0] forward_byte;
      logic                  integrity_clear;
      logic                  link_activity;
      logic                  frame_done;
      logic                  collided;
      logic                  busy_res;
   } rsp_item_type;

   // Frame store access from the core
   typedef struct packed {
      logic                  write;
      logic [ADDR_WIDTH-1:0] waddr;
      logic [BYTE_WIDTH-1:0] wdata;
      logic [ADDR_WIDTH-1:0] raddr_send;
      logic [ADDR_WIDTH-1:0] raddr_verify;
   } mem_ctl_type;

endpackage

/* rtl/iect_frame_store.sv */
// Frame byte store: one write port, two registered read ports, write-first.
module iect_frame_store
   import iect_pkg::*;
(
   input  logic                  clock,
   input  mem_ctl_type           ctl,
   output logic [BYTE_WIDTH-1:0] send_rd,
   output logic [BYTE_WIDTH-1:0] verify_rd
);

   logic [BYTE_WIDTH-1:0] mem [FRAME_DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (ctl.write) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
   end

   // Read ports, new data forwarded on a same-address write
   always_ff @(posedge clock) begin
      if (ctl.write && ctl.waddr == ctl.raddr_send) begin
         send_rd <= ctl.wdata;
      end else begin
         send_rd <= mem[ctl.raddr_send];
      end
      if (ctl.write && ctl.waddr == ctl.raddr_verify) begin
         verify_rd <= ctl.wdata;
      end else begin
         verify_rd <= mem[ctl.raddr_verify];
      end
   end

endmodule

/* rtl/iect_core.sv */
// Link state and per-item update: start, send, echo check, backoff.
module iect_core
   import iect_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  req_item_type          item,
   input  cfg_type               cfg,
   input  logic [BYTE_WIDTH-1:0] send_rd,
   input  logic [BYTE_WIDTH-1:0] verify_rd,
   output mem_ctl_type           mem_ctl,
   output rsp_item_type          result
);

   logic [TIME_WIDTH-1:0]  time_ff, time_in;
   logic [TIME_WIDTH-1:0]  allow_ff, allow_in;
   link_mode_type          mode_ff, mode_in;
   logic                   pending_ff, pending_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] send_idx_ff, send_idx_in;
   logic [COUNT_WIDTH-1:0] verify_idx_ff, verify_idx_in;
   logic [BYTE_WIDTH-1:0]  last_ff, last_in;

   logic                   active;
   logic                   busy;
   logic                   begin_check;
   logic                   push;
   logic                   fin;
   logic                   fin_coll;
   logic                   load_ok;
   logic [TIME_WIDTH-1:0]  gap_time;
   logic [BYTE_WIDTH-1:0]  last_byte;
   logic [BYTE_WIDTH-1:0]  nibble;
   logic [BYTE_WIDTH-1:0]  wait_ticks;
   logic [COUNT_WIDTH-1:0] verify_next;

   assign active = (mode_ff == MODE_ACTIVE);
   assign busy   = active || pending_ff;

   // Item update
   always_comb begin
      time_in       = time_ff;
      allow_in      = allow_ff;
      mode_in       = mode_ff;
      pending_in    = pending_ff;
      count_in      = count_ff;
      send_idx_in   = send_idx_ff;
      verify_idx_in = verify_idx_ff;
      last_in       = last_ff;
      begin_check   = 1'b0;
      push          = 1'b0;
      fin           = 1'b0;
      fin_coll      = 1'b0;
      load_ok       = 1'b0;
      result        = '0;
      verify_next   = verify_idx_ff + COUNT_WIDTH'(1);

      case (req_code_type'(item.code))
         REQ_TICK: begin
            time_in     = time_ff + TIME_WIDTH'(1);
            begin_check = 1'b1;
         end
         REQ_LOAD: begin
            if (!busy && count_ff < COUNT_WIDTH'(FRAME_DEPTH)) begin
               load_ok  = 1'b1;
               count_in = count_ff + COUNT_WIDTH'(1);
               last_in  = item.data;
            end
         end
         REQ_START: begin
            if (!busy) begin
               pending_in  = 1'b1;
               begin_check = 1'b1;
            end
         end
         REQ_SLOT: begin
            if (active && send_idx_ff < count_ff) begin
               result.send_valid = 1'b1;
               result.send_byte  = send_rd;
               send_idx_in       = send_idx_ff + COUNT_WIDTH'(1);
            end
         end
         REQ_RX: begin
            result.link_activity = 1'b1;
            if (!active) begin
               push                 = 1'b1;
               result.forward_valid = 1'b1;
               result.forward_byte  = item.data;
            end else if (verify_idx_ff >= count_ff || verify_rd != item.data) begin
               fin      = 1'b1;
               fin_coll = 1'b1;
            end else begin
               verify_idx_in = verify_next;
               if (verify_next >= count_ff) begin
                  fin = 1'b1;
               end
            end
         end
         REQ_RX_ERR: begin
            if (!active) begin
               result.integrity_clear = 1'b1;
               push                   = 1'b1;
            end else begin
               fin      = 1'b1;
               fin_coll = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Pending start begins once the allow time is reached
      if (begin_check && pending_in && !(time_in < allow_ff)) begin
         pending_in           = 1'b0;
         result.link_activity = 1'b1;
         send_idx_in          = '0;
         verify_idx_in        = '0;
         mode_in              = MODE_ACTIVE;
         if (count_ff == '0) begin
            fin = 1'b1;
         end
      end

      // Foreign traffic pushes the allow time out
      gap_time = time_in + TIME_WIDTH'(cfg.byte_safe_gap);
      if (push && gap_time > allow_ff) begin
         allow_in = gap_time;
      end

      // Completion and backoff
      last_byte  = (count_ff != '0) ? last_ff : '0;
      nibble     = BACKOFF_MASK & (count_ff[BYTE_WIDTH-1:0] + last_byte +
                                   time_in[BYTE_WIDTH-1:0]);
      wait_ticks = fin_coll ? (cfg.wait_coll + nibble) : cfg.wait_ok;
      if (fin) begin
         allow_in          = time_in + TIME_WIDTH'(wait_ticks);
         mode_in           = fin_coll ? MODE_COLL : MODE_IDLE;
         count_in          = '0;
         send_idx_in       = '0;
         verify_idx_in     = '0;
         result.frame_done = 1'b1;
         result.collided   = fin_coll;
      end

      result.busy_res = (mode_in == MODE_ACTIVE) || pending_in;
   end

   // Frame store access; read addresses follow the next index values
   always_comb begin
      mem_ctl.write = fire && load_ok;
      mem_ctl.waddr = count_ff[ADDR_WIDTH-1:0];
      mem_ctl.wdata = item.data;
      if (reset) begin
         mem_ctl.raddr_send   = '0;
         mem_ctl.raddr_verify = '0;
      end else if (fire) begin
         mem_ctl.raddr_send   = send_idx_in[ADDR_WIDTH-1:0];
         mem_ctl.raddr_verify = verify_idx_in[ADDR_WIDTH-1:0];
      end else begin
         mem_ctl.raddr_send   = send_idx_ff[ADDR_WIDTH-1:0];
         mem_ctl.raddr_verify = verify_idx_ff[ADDR_WIDTH-1:0];
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff       <= '0;
         allow_ff      <= '0;
         mode_ff       <= MODE_IDLE;
         pending_ff    <= 1'b0;
         count_ff      <= '0;
         send_idx_ff   <= '0;
         verify_idx_ff <= '0;
         last_ff       <= '0;
      end else if (fire) begin
         time_ff       <= time_in;
         allow_ff      <= allow_in;
         mode_ff       <= mode_in;
         pending_ff    <= pending_in;
         count_ff      <= count_in;
         send_idx_ff   <= send_idx_in;
         verify_idx_ff <= verify_idx_in;
         last_ff       <= last_in;
      end
   end

   // Checks
   a_send_only_active: assert property (@(posedge clock) disable iff (reset)
      fire && result.send_valid |-> mode_ff == MODE_ACTIVE)
      else $error("byte sent while link not active");

   a_done_clears_count: assert property (@(posedge clock) disable iff (reset)
      fire && result.frame_done |=> count_ff == '0 && mode_ff != MODE_ACTIVE)
      else $error("frame completion did not clear the frame");

   a_index_bounds: assert property (@(posedge clock) disable iff (reset)
      send_idx_ff <= count_ff && verify_idx_ff <= count_ff &&
      count_ff <= COUNT_WIDTH'(FRAME_DEPTH))
      else $error("frame index beyond loaded count");

   a_begin_pulses: assert property (@(posedge clock) disable iff (reset)
      fire && pending_ff && !pending_in && !fin |-> result.link_activity &&
      mode_in == MODE_ACTIVE)
      else $error("frame began without activity pulse");

endmodule

/* rtl/ir_echo_collision_transmitter_top.sv */
// Top level: item registers, configuration registers, core and frame store.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_type, req_data_byte
//  rsp      out        rsp_valid/rsp_stall  rsp_send_* .. rsp_busy_res
//  csr      in         csr_write            csr_index, csr_wdata
//
// One item per cycle sustained while rsp_stall is low; an item's result, the
// state update on the input register, is captured in the result register when
// the item fires. The frame store's read ports are addressed from the next
// index values. Reset is synchronous; the frame store has no clearing pass and
// holds unknown data until bytes are loaded. A stalled result holds the result
// register, and the input register then takes one more item before req_stall.
module ir_echo_collision_transmitter_top
   import iect_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CODE_WIDTH-1:0]      req_type,
   input  logic [BYTE_WIDTH-1:0]      req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_send_valid,
   output logic [BYTE_WIDTH-1:0]      rsp_send_byte,
   output logic                       rsp_forward_valid,
   output logic [BYTE_WIDTH-1:0]      rsp_forward_byte,
   output logic                       rsp_integrity_clear,
   output logic                       rsp_link_activity,
   output logic                       rsp_frame_done,
   output logic                       rsp_collided,
   output logic                       rsp_busy_res,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [BYTE_WIDTH-1:0]      csr_wdata
);

   logic          in_valid_ff;
   req_item_type  in_item_ff;
   logic          out_valid_ff;
   rsp_item_type  out_item_ff;
   cfg_type       cfg_ff;
   logic          fire;
   logic          req_take;
   rsp_item_type  result;
   mem_ctl_type   mem_ctl;
   logic [BYTE_WIDTH-1:0] send_rd;
   logic [BYTE_WIDTH-1:0] verify_rd;

   // Handshake
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.code <= req_type;
         in_item_ff.data <= req_data_byte;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.byte_safe_gap <= BYTE_SAFE_GAP_RESET;
         cfg_ff.wait_ok       <= WAIT_OK_RESET;
         cfg_ff.wait_coll     <= WAIT_COLL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BYTE_SAFE_GAP: cfg_ff.byte_safe_gap <= csr_wdata;
            CSR_WAIT_OK:       cfg_ff.wait_ok       <= csr_wdata;
            CSR_WAIT_COLL:     cfg_ff.wait_coll     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   iect_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_item_ff),
      .cfg       (cfg_ff),
      .send_rd   (send_rd),
      .verify_rd (verify_rd),
      .mem_ctl   (mem_ctl),
      .result    (result)
   );

   iect_frame_store u_store (
      .clock     (clock),
      .ctl       (mem_ctl),
      .send_rd   (send_rd),
      .verify_rd (verify_rd)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_send_valid      = out_item_ff.send_valid;
   assign rsp_send_byte       = out_item_ff.send_byte;
   assign rsp_forward_valid   = out_item_ff.forward_valid;
   assign rsp_forward_byte    = out_item_ff.forward_byte;
   assign rsp_integrity_clear = out_item_ff.integrity_clear;
   assign rsp_link_activity   = out_item_ff.link_activity;
   assign rsp_frame_done      = out_item_ff.frame_done;
   assign rsp_collided        = out_item_ff.collided;
   assign rsp_busy_res        = out_item_ff.busy_res;

endmodule
